@@ hw/rtl/mepc_pkg.sv @@
// ----------------------------------------------------------------------------
// mepc_pkg: shared constants for the moisture EMA pump controller
// Group size, smoothing divisor, field and divider widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package mepc_pkg;

    // Attempts per group and EMA divisor (1..16 and 1..64)
    localparam int SAMPLES_PER_READING = 16;
    localparam int EMA_DIVISOR         = 8;

    // Attempt counter width, at least one bit
    localparam int ATT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;

    // Field widths
    localparam int RAW_W = 12;
    localparam int PCT_W = 7;
    localparam int SUM_W = 16;
    localparam int CNT_W = 5;

    // Shared divider: dividend holds (4095 * 100), divisor holds 12 bits
    localparam int DIV_N  = 19;
    localparam int DIV_D  = 12;
    localparam int STEP_W = 5;

    // Calibration constants
    localparam int PCT_FULL = 100;
    localparam int RAW_MAX  = 4095;

    // Configuration register indexes
    localparam logic [1:0] REG_WET    = 2'd0;
    localparam logic [1:0] REG_DRY    = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;
    localparam logic [1:0] REG_ORIENT = 2'd3;

    // Orientation codes
    localparam logic [1:0] ORIENT_AUTO     = 2'd0;
    localparam logic [1:0] ORIENT_WET_LOW  = 2'd1;
    localparam logic [1:0] ORIENT_WET_HIGH = 2'd2;

    // Reset values of the registers
    localparam logic [RAW_W-1:0] WET_RESET    = 12'd3800;
    localparam logic [RAW_W-1:0] DRY_RESET    = 12'd3900;
    localparam logic [PCT_W-1:0] THRESH_RESET = 7'd50;

endpackage

@@ hw/rtl/moisture_ema_pump_control.sv @@
// ----------------------------------------------------------------------------
// moisture_ema_pump_control: averaged, smoothed and calibrated soil moisture
// Groups converter attempts, averages, smooths with an EMA and drives the pump.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one converter attempt
//   per beat: i_sample_value and i_sample_ok. Every SAMPLES_PER_READING
//   beats close a group and produce one result beat on the output channel
//   (o_out_valid / i_out_ready): percent, wet flag, pump request, sensor
//   error and the smoothed raw value.
//   Input flow: a beat that does not close a group is taken at once while
//   the sequencer is idle. The beat that closes a group holds o_in_ready
//   low while the sequencer runs: a pass through the shared restoring
//   divider for the average, the EMA step, a second divider pass for the
//   percent unless the reading sits at or beyond a reference or the two
//   references are equal, and the hand-off, which waits until the output
//   register is free.
//   The result sits in an output register; if the receiver stalls, the
//   next non-closing beats are still taken, and a following group result
//   waits in the sequencer until the register is free.
//   Reset (i_rst_n low, synchronous): registers return to 3800 / 3900 /
//   50 / automatic, counters and the EMA clear, and the EMA is re-seeded
//   by the first group after reset.
//   Configuration writes (i_cfg_we) take effect at once, no wait.
// ----------------------------------------------------------------------------
module moisture_ema_pump_control (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [mepc_pkg::RAW_W-1:0]       i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [mepc_pkg::RAW_W-1:0]       i_sample_value,
    input  logic                             i_sample_ok,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [mepc_pkg::PCT_W-1:0]       o_soil_pct,
    output logic                             o_is_wet,
    output logic                             o_pump_on,
    output logic                             o_sensor_error,
    output logic [mepc_pkg::RAW_W-1:0]       o_smoothed_raw
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_EMA  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_PCT  = 3'd4;
    localparam logic [2:0] S_PLD  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    // What the divider is working on
    localparam logic [1:0] PH_AVG = 2'd0;
    localparam logic [1:0] PH_PCT = 2'd2;

    localparam int RAW_W = mepc_pkg::RAW_W;
    localparam int PCT_W = mepc_pkg::PCT_W;
    localparam int DIV_N = mepc_pkg::DIV_N;
    localparam int DIV_D = mepc_pkg::DIV_D;

    // Configuration registers
    logic [RAW_W-1:0] r_wet;
    logic [RAW_W-1:0] r_dry;
    logic [PCT_W-1:0] r_thresh;
    logic [1:0]       r_orient;

    // Group accumulation
    logic [mepc_pkg::SUM_W-1:0] r_sum;
    logic [mepc_pkg::CNT_W-1:0] r_good;
    logic [mepc_pkg::ATT_W-1:0] r_att;

    // Sequencer and EMA state
    logic [2:0]       r_state;
    logic [1:0]       r_phase;
    logic [RAW_W-1:0] r_ema;
    logic             r_started;
    logic             r_err;
    logic             r_neg;
    logic [PCT_W-1:0] r_pct;

    // Shared divider
    logic [mepc_pkg::STEP_W-1:0] r_step;
    logic [DIV_N-1:0]            r_dq;
    logic [DIV_D-1:0]            r_drem;
    logic [DIV_D-1:0]            r_dden;

    // Output register
    logic             r_out_valid;
    logic [PCT_W-1:0] r_o_pct;
    logic             r_o_wet;
    logic             r_o_pump;
    logic             r_o_err;
    logic [RAW_W-1:0] r_o_raw;

    // Accept and accumulate
    logic                       in_acc;
    logic                       grp_end;
    logic [mepc_pkg::SUM_W-1:0] sum_new;
    logic [mepc_pkg::CNT_W-1:0] good_new;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign grp_end    = (r_att == mepc_pkg::ATT_W'(mepc_pkg::SAMPLES_PER_READING - 1));
    assign sum_new    = r_sum + (i_sample_ok ? mepc_pkg::SUM_W'(i_sample_value)
                                             : mepc_pkg::SUM_W'(0));
    assign good_new   = r_good + (i_sample_ok ? mepc_pkg::CNT_W'(1) : mepc_pkg::CNT_W'(0));

    // Divider step: shift one dividend bit into the remainder, try subtract
    logic [DIV_D:0] d_trial;
    logic [DIV_D:0] d_diff;
    logic           d_ge;
    logic           d_last;

    assign d_trial = {r_drem, r_dq[DIV_N-1]};
    assign d_diff  = d_trial - {1'b0, r_dden};
    assign d_ge    = (d_trial >= {1'b0, r_dden});
    assign d_last  = (r_step == mepc_pkg::STEP_W'(DIV_N - 1));

    // Average with clamp, zero on an empty group
    logic [RAW_W-1:0] avg_q;
    logic [RAW_W:0]   ema_diff;
    logic [RAW_W-1:0] ema_mag;

    always_comb begin
        if (r_err) begin
            avg_q = '0;
        end else if (|r_dq[DIV_N-1:RAW_W]) begin
            avg_q = RAW_W'(mepc_pkg::RAW_MAX);
        end else begin
            avg_q = r_dq[RAW_W-1:0];
        end
        ema_diff = {1'b0, avg_q} - {1'b0, r_ema};
        ema_mag  = ema_diff[RAW_W] ? RAW_W'(-ema_diff) : ema_diff[RAW_W-1:0];
    end

    // EMA update with clamp to 0..4095
    logic [RAW_W+1:0] upd_step;
    logic [RAW_W+1:0] upd_sum;
    logic [RAW_W-1:0] upd_ema;

    always_comb begin
        upd_step = r_neg ? -{2'b00, r_dq[RAW_W-1:0]} : {2'b00, r_dq[RAW_W-1:0]};
        upd_sum  = {2'b00, r_ema} + upd_step;
        if (upd_sum[RAW_W+1]) begin
            upd_ema = '0;
        end else if (upd_sum[RAW_W]) begin
            upd_ema = RAW_W'(mepc_pkg::RAW_MAX);
        end else begin
            upd_ema = upd_sum[RAW_W-1:0];
        end
    end

    // Calibration setup: fixed answer or numerator / denominator
    logic             wet_low;
    logic             pct_fix;
    logic [PCT_W-1:0] pct_val;
    logic [RAW_W-1:0] cal_span;
    logic [RAW_W-1:0] cal_dist;
    logic [DIV_N-1:0] cal_num;

    always_comb begin
        case (r_orient)
            mepc_pkg::ORIENT_WET_LOW:  wet_low = 1'b1;
            mepc_pkg::ORIENT_WET_HIGH: wet_low = 1'b0;
            default:                   wet_low = (r_wet < r_dry);
        endcase
        pct_fix  = 1'b1;
        pct_val  = '0;
        cal_span = '0;
        cal_dist = '0;
        if (r_wet == r_dry) begin
            pct_val = '0;
        end else if (wet_low) begin
            if (r_ema <= r_wet) begin
                pct_val = PCT_W'(mepc_pkg::PCT_FULL);
            end else if (r_ema >= r_dry) begin
                pct_val = '0;
            end else begin
                pct_fix  = 1'b0;
                cal_dist = r_dry - r_ema;
                cal_span = r_dry - r_wet;
            end
        end else begin
            if (r_ema >= r_wet) begin
                pct_val = PCT_W'(mepc_pkg::PCT_FULL);
            end else if (r_ema <= r_dry) begin
                pct_val = '0;
            end else begin
                pct_fix  = 1'b0;
                cal_dist = r_ema - r_dry;
                cal_span = r_wet - r_dry;
            end
        end
        cal_num = DIV_N'(cal_dist) * DIV_N'(mepc_pkg::PCT_FULL);
    end

    // Result fields
    logic res_wet;
    assign res_wet = (r_pct > r_thresh);

    logic out_load;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wet    <= mepc_pkg::WET_RESET;
            r_dry    <= mepc_pkg::DRY_RESET;
            r_thresh <= mepc_pkg::THRESH_RESET;
            r_orient <= mepc_pkg::ORIENT_AUTO;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mepc_pkg::REG_WET:    r_wet    <= i_cfg_data;
                mepc_pkg::REG_DRY:    r_dry    <= i_cfg_data;
                mepc_pkg::REG_THRESH: r_thresh <= i_cfg_data[PCT_W-1:0];
                mepc_pkg::REG_ORIENT: r_orient <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, accumulators and EMA state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_AVG;
            r_sum     <= '0;
            r_good    <= '0;
            r_att     <= '0;
            r_ema     <= '0;
            r_started <= 1'b0;
            r_step    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (grp_end) begin
                            r_sum   <= '0;
                            r_good  <= '0;
                            r_att   <= '0;
                            r_err   <= (good_new == '0);
                            r_dq    <= DIV_N'(sum_new);
                            r_drem  <= '0;
                            r_dden  <= DIV_D'(good_new);
                            r_step  <= '0;
                            r_phase <= PH_AVG;
                            r_state <= S_DIV;
                        end else begin
                            r_sum  <= sum_new;
                            r_good <= good_new;
                            r_att  <= r_att + mepc_pkg::ATT_W'(1);
                        end
                    end
                end
                S_DIV: begin
                    r_drem <= d_ge ? d_diff[DIV_D-1:0] : d_trial[DIV_D-1:0];
                    r_dq   <= {r_dq[DIV_N-2:0], d_ge};
                    r_step <= r_step + mepc_pkg::STEP_W'(1);
                    if (d_last) begin
                        case (r_phase)
                            PH_AVG:  r_state <= S_EMA;
                            default: r_state <= S_PLD;
                        endcase
                    end
                end
                S_EMA: begin
                    if (!r_started) begin
                        // first group seeds the EMA
                        r_ema     <= avg_q;
                        r_started <= 1'b1;
                        r_state   <= S_PCT;
                    end else begin
                        // magnitude step, truncated toward zero
                        r_neg   <= ema_diff[RAW_W];
                        r_dq    <= DIV_N'(ema_mag / mepc_pkg::EMA_DIVISOR);
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_ema   <= upd_ema;
                    r_state <= S_PCT;
                end
                S_PCT: begin
                    if (pct_fix) begin
                        r_pct   <= pct_val;
                        r_state <= S_DONE;
                    end else begin
                        r_dq    <= cal_num;
                        r_drem  <= '0;
                        r_dden  <= cal_span;
                        r_step  <= '0;
                        r_phase <= PH_PCT;
                        r_state <= S_DIV;
                    end
                end
                S_PLD: begin
                    r_pct   <= r_dq[PCT_W-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_pct  <= r_pct;
            r_o_wet  <= res_wet;
            r_o_pump <= !r_err && !res_wet;
            r_o_err  <= r_err;
            r_o_raw  <= r_ema;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_soil_pct     = r_o_pct;
    assign o_is_wet       = r_o_wet;
    assign o_pump_on      = r_o_pump;
    assign o_sensor_error = r_o_err;
    assign o_smoothed_raw = r_o_raw;

endmodule

@@ hw/rtl/mepc_checker.sv @@
// ----------------------------------------------------------------------------
// mepc_checker: port-level checks for the moisture EMA pump controller
// Watches the result channel for stall behavior and field consistency.
// ----------------------------------------------------------------------------
module mepc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [mepc_pkg::PCT_W-1:0] i_soil_pct,
    input logic                       i_is_wet,
    input logic                       i_pump_on,
    input logic                       i_sensor_error,
    input logic [mepc_pkg::RAW_W-1:0] i_smoothed_raw
);

    // stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_soil_pct)
            && $stable(i_smoothed_raw) && $stable(i_pump_on))
        else $error("result beat changed while stalled");

    // percent stays in range
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_soil_pct <= mepc_pkg::PCT_W'(mepc_pkg::PCT_FULL))
        else $error("moisture percent above full scale");

    // pump request follows error and wet flags
    a_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_pump_on == (!i_sensor_error && !i_is_wet))
        else $error("pump request inconsistent with flags");

    // wet needs a nonzero percent
    a_wet_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_wet |-> i_soil_pct != '0)
        else $error("wet flag with zero percent");

endmodule

bind moisture_ema_pump_control mepc_checker u_mepc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_soil_pct     (o_soil_pct),
    .i_is_wet       (o_is_wet),
    .i_pump_on      (o_pump_on),
    .i_sensor_error (o_sensor_error),
    .i_smoothed_raw (o_smoothed_raw)
);
